// File: hdl/line_substring_match_filter_macros.svh
// Assertion macros shared by the line substring match filter RTL.
`ifndef LINE_SUBSTRING_MATCH_FILTER_MACROS_SVH
`define LINE_SUBSTRING_MATCH_FILTER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define LSMF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LSMF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define LSMF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define LSMF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// File: hdl/lsmf_pkg.sv
// Shared types, codes and helper functions of the line substring match filter.
`timescale 1ns / 1ps

package lsmf_pkg;

    // Byte codes used by the line splitter and the case folding.
    localparam logic [7:0] NL_BYTE  = 8'd10;
    localparam logic [7:0] UP_A     = 8'd65;
    localparam logic [7:0] UP_Z     = 8'd90;
    localparam logic [7:0] CASE_GAP = 8'd32;

    // Saturation value of the line and match counters.
    localparam logic [31:0] CNT_SAT = 32'hFFFF_FFFF;

    // Port widths.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int OUT_DATA_W = 72;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FOLD_CASE = 3'd0,
        CFG_INVERT    = 3'd1,
        CFG_PAT_LEN   = 3'd2,
        CFG_PAT_LO    = 3'd3,
        CFG_PAT_HI    = 3'd4
    } cfg_idx_t;

    // Input request kinds.
    typedef enum logic {
        OP_DATA = 1'b0,
        OP_EOS  = 1'b1
    } op_t;

    // Result kinds.
    typedef enum logic {
        KIND_LINE    = 1'b0,
        KIND_SUMMARY = 1'b1
    } kind_t;

    // Control group driven from the top level into the window scanner and its cells.
    typedef struct packed {
        logic push;
        logic clear;
        logic fold_case;
    } scan_ctrl_t;

    // One result request as held in the output queue.
    typedef struct packed {
        kind_t       kind;
        logic        matched;
        logic [31:0] line_number;
        logic [31:0] match_count;
        logic        any_selected;
        logic        last;
    } result_t;

    // Fold A-Z to lower case when enabled.
    function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic en);
        if (en && (b >= UP_A) && (b <= UP_Z)) begin
            return b + CASE_GAP;
        end
        return b;
    endfunction

endpackage

// File: hdl/lsmf_cell.sv
// One window cell: holds one earlier line byte and compares it with its pattern byte.
`timescale 1ns / 1ps

module lsmf_cell #(
    parameter int IDX     = 0,
    parameter int PAT_MAX = 16,
    parameter int LEN_W   = 5
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  lsmf_pkg::scan_ctrl_t     ctrl,
    input  logic [7:0]               byte_in,
    input  logic [PAT_MAX*8-1:0]     pat_flat,
    input  logic [LEN_W-1:0]         pat_len,
    output logic [7:0]               byte_out,
    output logic                     miss
);
    import lsmf_pkg::*;

    logic [7:0] byte_reg;
    logic [7:0] byte_next;
    logic [7:0] pat_sel;
    logic       active;

    // This cell holds the byte IDX+1 places back, so it meets pattern byte len-2-IDX.
    always_comb
    begin
        active  = (32'(pat_len) >= IDX + 2);
        pat_sel = '0;
        for (int j = 0; j < PAT_MAX; j++)
        begin
            if (32'(pat_len) == j + IDX + 2)
            begin
                pat_sel = pat_flat[j*8 +: 8];
            end
        end
        miss = active && (fold_byte(byte_reg, ctrl.fold_case) != fold_byte(pat_sel, ctrl.fold_case));
    end

    // Shift the neighbor's byte in on each line byte; a finished line empties the cell.
    always_comb
    begin
        if (ctrl.clear)
        begin
            byte_next = '0;
        end
        else if (ctrl.push)
        begin
            byte_next = byte_in;
        end
        else
        begin
            byte_next = byte_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= '0;
        end
        else
        begin
            byte_reg <= byte_next;
        end
    end

    assign byte_out = byte_reg;

endmodule

// File: hdl/lsmf_scan.sv
// Window scanner: a chain of byte cells plus the per-line hit flag and byte count.
`timescale 1ns / 1ps

module lsmf_scan #(
    parameter int PAT_MAX = 16,
    parameter int LEN_W   = 5
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  lsmf_pkg::scan_ctrl_t     ctrl,
    input  logic [7:0]               data_byte,
    input  logic [PAT_MAX*8-1:0]     pat_flat,
    input  logic [LEN_W-1:0]         pat_len,
    output logic                     line_hit,
    output logic                     line_busy
);
    import lsmf_pkg::*;

    // At least one cell is kept so the chain is never empty.
    localparam int CELLS = (PAT_MAX > 1) ? PAT_MAX - 1 : 1;

    logic [7:0]       win [CELLS];
    logic [CELLS-1:0] miss;
    logic [7:0]       head_pat;
    logic             head_eq;
    logic [LEN_W-1:0] seen;
    logic             hit_now;
    logic [LEN_W-1:0] bytes_in_line_reg;
    logic [LEN_W-1:0] bytes_in_line_next;
    logic             line_hit_reg;
    logic             line_hit_next;

    // Chain of cells; cell 0 takes the incoming byte, each later cell its neighbor's.
    for (genvar k = 0; k < CELLS; k++)
    begin : g_cell
        logic [7:0] cell_in;
        if (k == 0)
        begin : g_first
            assign cell_in = data_byte;
        end
        else
        begin : g_next
            assign cell_in = win[k-1];
        end
        lsmf_cell #(
            .IDX     (k),
            .PAT_MAX (PAT_MAX),
            .LEN_W   (LEN_W)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .byte_in  (cell_in),
            .pat_flat (pat_flat),
            .pat_len  (pat_len),
            .byte_out (win[k]),
            .miss     (miss[k])
        );
    end

    // The incoming byte meets the last pattern byte.
    always_comb
    begin
        head_pat = '0;
        for (int j = 0; j < PAT_MAX; j++)
        begin
            if (32'(pat_len) == j + 1)
            begin
                head_pat = pat_flat[j*8 +: 8];
            end
        end
        head_eq = (fold_byte(data_byte, ctrl.fold_case) == fold_byte(head_pat, ctrl.fold_case));
    end

    // Byte count including this byte, saturating at the window size.
    always_comb
    begin
        if (32'(bytes_in_line_reg) < PAT_MAX)
        begin
            seen = bytes_in_line_reg + LEN_W'(1);
        end
        else
        begin
            seen = LEN_W'(PAT_MAX);
        end
        hit_now = ctrl.push && (pat_len != '0) && (seen >= pat_len) && head_eq && !(|miss);
    end

    // Sticky hit flag and line byte count.
    always_comb
    begin
        if (ctrl.clear)
        begin
            bytes_in_line_next = '0;
            line_hit_next      = 1'b0;
        end
        else
        begin
            bytes_in_line_next = ctrl.push ? seen : bytes_in_line_reg;
            line_hit_next      = line_hit_reg || hit_now;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_in_line_reg <= '0;
            line_hit_reg      <= 1'b0;
        end
        else
        begin
            bytes_in_line_reg <= bytes_in_line_next;
            line_hit_reg      <= line_hit_next;
        end
    end

    assign line_hit  = line_hit_reg;
    assign line_busy = (bytes_in_line_reg != '0);

endmodule

// File: hdl/lsmf_out_fifo.sv
// Four-entry result queue that takes up to two results per cycle and gives at most one.
`timescale 1ns / 1ps

module lsmf_out_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [1:0]          wr_cnt,
    input  lsmf_pkg::result_t   wr_data0,
    input  lsmf_pkg::result_t   wr_data1,
    input  logic                rd_ready,
    output logic                rd_valid,
    output lsmf_pkg::result_t   rd_data,
    output logic                room_two
);
    import lsmf_pkg::*;

    result_t    entry_reg [4];
    logic [1:0] wr_ptr_reg;
    logic [1:0] wr_ptr_next;
    logic [1:0] rd_ptr_reg;
    logic [1:0] rd_ptr_next;
    logic [2:0] count_reg;
    logic [2:0] count_next;
    logic       pop;

    assign rd_valid = (count_reg != 3'd0);
    assign rd_data  = entry_reg[rd_ptr_reg];
    assign room_two = (count_reg <= 3'd2);
    assign pop      = rd_valid && rd_ready;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + wr_cnt;
        rd_ptr_next = rd_ptr_reg + 2'(pop);
        count_next  = count_reg + 3'(wr_cnt) - 3'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Result storage; the second result goes in the slot after the first.
    always_ff @(posedge clk)
    begin
        if (wr_cnt != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= wr_data0;
        end
        if (wr_cnt == 2'd2)
        begin
            entry_reg[wr_ptr_reg + 2'd1] <= wr_data1;
        end
    end

endmodule

// File: hdl/line_substring_match_filter.sv
// Top level of the line substring match filter: registers, line counters and stream ports.
`timescale 1ns / 1ps

// Fixed-string line matcher. Stream bytes enter on s_axis (tuser 0 for a data byte,
// 1 for end of stream); a newline closes a line and gives one verdict with its line
// number and running match count, and end of stream gives the verdict of a pending
// unterminated line, if any, followed by a summary, after which the counters restart.
// One request is accepted per clock cycle while s_axis_tready is high: every byte
// is compared against the pattern in the same cycle by a chain of PAT_MAX-1 window
// cells, so the rate is one byte per cycle; results are registered in the result queue.
// s_axis_tready is low only while the four-entry result queue holds more than two
// results, which happens only when m_axis is held off. Configuration is taken at any
// time on the cfg channel and must be written while no result is outstanding.
`include "line_substring_match_filter_macros.svh"

module line_substring_match_filter #(
    parameter int PAT_MAX = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // Input stream.
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [7:0]                            s_axis_tdata,  // [7:0] data_byte
    input  logic [0:0]                            s_axis_tuser,  // [0] op
    // Result stream.
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // [0] line_matched, [32:1] line_number, [64:33] match_count, [65] any_selected,
    // [71:66] zero
    output logic [lsmf_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
    output logic [0:0]                            m_axis_tuser,  // [0] result_kind
    output logic                                  m_axis_tlast,  // last_result
    // Configuration writes.
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [lsmf_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [lsmf_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import lsmf_pkg::*;

    localparam int LEN_W = $clog2(PAT_MAX + 1);

    // Configuration registers.
    logic                 fold_case_reg;
    logic                 invert_reg;
    logic [4:0]           pat_len_reg;
    logic [63:0]          pat_lo_reg;
    logic [63:0]          pat_hi_reg;

    // Stream counters.
    logic [31:0]          line_cnt_reg;
    logic [31:0]          line_cnt_next;
    logic [31:0]          sel_cnt_reg;
    logic [31:0]          sel_cnt_next;
    logic                 any_sel_reg;
    logic                 any_sel_next;

    logic [PAT_MAX*8-1:0] pat_flat;
    logic [LEN_W-1:0]     pat_len;
    logic                 in_acc;
    logic                 is_nl;
    logic                 eos_acc;
    logic                 nl_acc;
    logic                 judge;
    logic                 line_hit;
    logic                 line_busy;
    logic                 verdict;
    logic [31:0]          ln_inc;
    logic [31:0]          sel_after;
    logic                 any_after;
    scan_ctrl_t           scan_ctrl;
    result_t              line_res;
    result_t              sum_res;
    result_t              wr_data0;
    logic [1:0]           wr_cnt;
    logic                 room_two;
    result_t              rd_data;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fold_case_reg <= 1'b0;
            invert_reg    <= 1'b0;
            pat_len_reg   <= '0;
            pat_lo_reg    <= '0;
            pat_hi_reg    <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_FOLD_CASE: fold_case_reg <= cfg_data[0];
                CFG_INVERT:    invert_reg    <= cfg_data[0];
                CFG_PAT_LEN:   pat_len_reg   <= cfg_data[4:0];
                CFG_PAT_LO:    pat_lo_reg    <= cfg_data;
                CFG_PAT_HI:    pat_hi_reg    <= cfg_data;
                default:       ;
            endcase
        end
    end

    // Pattern bytes laid out for the window; bytes from position 16 on read as zero.
    for (genvar j = 0; j < PAT_MAX; j++)
    begin : g_pat
        if (j < 8)
        begin : g_lo
            assign pat_flat[j*8 +: 8] = pat_lo_reg[j*8 +: 8];
        end
        else if (j < 16)
        begin : g_hi
            assign pat_flat[j*8 +: 8] = pat_hi_reg[(j-8)*8 +: 8];
        end
        else
        begin : g_zero
            assign pat_flat[j*8 +: 8] = 8'd0;
        end
    end

    // Pattern length clamped to the window size.
    always_comb
    begin
        if (32'(pat_len_reg) > PAT_MAX)
        begin
            pat_len = LEN_W'(PAT_MAX);
        end
        else
        begin
            pat_len = LEN_W'(pat_len_reg);
        end
    end

    // Request decode.
    always_comb
    begin
        in_acc  = s_axis_tvalid && s_axis_tready;
        is_nl   = (s_axis_tdata == NL_BYTE);
        eos_acc = in_acc && (op_t'(s_axis_tuser[0]) == OP_EOS);
        nl_acc  = in_acc && (op_t'(s_axis_tuser[0]) == OP_DATA) && is_nl;
        judge   = nl_acc || (eos_acc && line_busy);

        scan_ctrl.push      = in_acc && (op_t'(s_axis_tuser[0]) == OP_DATA) && !is_nl;
        scan_ctrl.clear     = nl_acc || eos_acc;
        scan_ctrl.fold_case = fold_case_reg;
    end

    lsmf_scan #(
        .PAT_MAX (PAT_MAX),
        .LEN_W   (LEN_W)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (scan_ctrl),
        .data_byte (s_axis_tdata),
        .pat_flat  (pat_flat),
        .pat_len   (pat_len),
        .line_hit  (line_hit),
        .line_busy (line_busy)
    );

    // Line verdict and the counter values that follow it.
    always_comb
    begin
        verdict   = ((pat_len == '0) || line_hit) ^ invert_reg;
        ln_inc    = (line_cnt_reg == CNT_SAT) ? line_cnt_reg : line_cnt_reg + 32'd1;
        if (verdict && (sel_cnt_reg != CNT_SAT))
        begin
            sel_after = sel_cnt_reg + 32'd1;
        end
        else
        begin
            sel_after = sel_cnt_reg;
        end
        any_after = any_sel_reg || verdict;
    end

    // Result requests for this input request.
    always_comb
    begin
        line_res.kind         = KIND_LINE;
        line_res.matched      = verdict;
        line_res.line_number  = ln_inc;
        line_res.match_count  = sel_after;
        line_res.any_selected = any_after;
        line_res.last         = nl_acc;

        sum_res.kind          = KIND_SUMMARY;
        sum_res.matched       = 1'b0;
        sum_res.line_number   = judge ? ln_inc : line_cnt_reg;
        sum_res.match_count   = judge ? sel_after : sel_cnt_reg;
        sum_res.any_selected  = judge ? any_after : any_sel_reg;
        sum_res.last          = 1'b1;

        if (eos_acc && line_busy)
        begin
            wr_cnt   = 2'd2;
            wr_data0 = line_res;
        end
        else if (eos_acc)
        begin
            wr_cnt   = 2'd1;
            wr_data0 = sum_res;
        end
        else if (nl_acc)
        begin
            wr_cnt   = 2'd1;
            wr_data0 = line_res;
        end
        else
        begin
            wr_cnt   = 2'd0;
            wr_data0 = line_res;
        end
    end

    // Counter update; end of stream starts a fresh stream.
    always_comb
    begin
        if (eos_acc)
        begin
            line_cnt_next = '0;
            sel_cnt_next  = '0;
            any_sel_next  = 1'b0;
        end
        else if (judge)
        begin
            line_cnt_next = ln_inc;
            sel_cnt_next  = sel_after;
            any_sel_next  = any_after;
        end
        else
        begin
            line_cnt_next = line_cnt_reg;
            sel_cnt_next  = sel_cnt_reg;
            any_sel_next  = any_sel_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_cnt_reg <= '0;
            sel_cnt_reg  <= '0;
            any_sel_reg  <= 1'b0;
        end
        else
        begin
            line_cnt_reg <= line_cnt_next;
            sel_cnt_reg  <= sel_cnt_next;
            any_sel_reg  <= any_sel_next;
        end
    end

    // Result queue between the scanner and the output stream.
    lsmf_out_fifo u_out_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_cnt   (wr_cnt),
        .wr_data0 (wr_data0),
        .wr_data1 (sum_res),
        .rd_ready (m_axis_tready),
        .rd_valid (m_axis_tvalid),
        .rd_data  (rd_data),
        .room_two (room_two)
    );

    assign s_axis_tready = room_two;
    assign m_axis_tdata  = {6'd0, rd_data.any_selected, rd_data.match_count,
                            rd_data.line_number, rd_data.matched};
    assign m_axis_tuser  = rd_data.kind;
    assign m_axis_tlast  = rd_data.last;

    // Checks on the counter logic.
    `LSMF_ASSERT_NXT(a_eos_restart, clk, rst_n, eos_acc,
        (line_cnt_reg == 32'd0) && (sel_cnt_reg == 32'd0) && !any_sel_reg,
        "counters not cleared after end of stream")
    `LSMF_ASSERT_IMP(a_sel_le_line, clk, rst_n, 1'b1, sel_cnt_reg <= line_cnt_reg,
        "more selected lines than judged lines")
    `LSMF_ASSERT_IMP(a_any_vs_count, clk, rst_n, 1'b1, any_sel_reg == (sel_cnt_reg != 32'd0),
        "any-selected flag disagrees with the match count")
    `LSMF_ASSERT_IMP(a_any_falls_on_eos, clk, rst_n, $fell(any_sel_reg), $past(eos_acc),
        "any-selected flag dropped without end of stream")

endmodule
